// ----- hw/rtl/sets_pkg.sv -----
// ============================================================================
// sets_pkg: shared types and constants of the eight-way tree search
// Table geometry, lane control structures and level codes used by the
// sequencer and the lane cells.
// ============================================================================
`default_nettype none

package sets_pkg;

    // Table geometry: eight lanes, three pivot levels, 4096 key slots.
    localparam int LANES     = 8;
    localparam int LANE_W    = 3;
    localparam int KEY_W     = 64;
    localparam int SLOT_W    = 12;
    localparam int COUNT_W   = 13;
    localparam int MAX_KEYS  = 4096;
    localparam int KEY_ROWS  = 512;
    localparam int KEY_ROW_W = 9;
    localparam int MID_ROWS  = 8;
    localparam int MID_ROW_W = 3;
    localparam int BOT_ROWS  = 64;
    localparam int BOT_ROW_W = 6;
    localparam int NODE_W    = 9;
    localparam int CNT_W     = 4;

    // Pivot level that the cells compare against.
    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_MID = 2'd1;
    localparam logic [1:0] LVL_BOT = 2'd2;

    // Command code of an input transaction.
    localparam logic CMD_LOAD = 1'b0;

    // Control broadcast to every lane cell.
    typedef struct packed {
        logic [1:0]           lvl;
        logic [KEY_W-1:0]     data;
        logic [NODE_W-1:0]    node;
        logic [KEY_ROW_W-1:0] key_row;
        logic [MID_ROW_W-1:0] mid_row;
        logic                 mid_fill;
        logic [BOT_ROW_W-1:0] bot_row;
        logic                 high_hit;
    } cell_bcast_t;

    // Per-lane write enables and leaf qualifier.
    typedef struct packed {
        logic key_we;
        logic top_we;
        logic mid_we;
        logic bot_we;
        logic leaf_live;
    } cell_lane_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sets_cell.sv -----
// ============================================================================
// sets_cell: one lane of the search row
// Holds one lane of every pivot level and of the key table, compares its
// pivot or key against the search value and extends the neighbor's results.
// ============================================================================
`default_nettype none

module sets_cell (
    input  wire logic                        clk,
    input  wire sets_pkg::cell_bcast_t       bcast,
    input  wire sets_pkg::cell_lane_t        lane,
    input  wire logic [sets_pkg::CNT_W-1:0]  cnt_in,
    input  wire logic                        found_in,
    output logic      [sets_pkg::CNT_W-1:0]  cnt_out,
    output logic                             found_out
);
    import sets_pkg::*;

    logic [KEY_W-1:0] top_reg;
    logic [KEY_W-1:0] mid_reg [MID_ROWS];
    logic [KEY_W-1:0] bot_mem [BOT_ROWS];
    logic [KEY_W-1:0] key_mem [KEY_ROWS];
    logic [KEY_W-1:0] bot_rdata_reg;
    logic [KEY_W-1:0] key_rdata_reg;
    logic [KEY_W-1:0] pivot;
    logic             less;
    logic             hit;

    // Top and middle pivots live in flip-flops; a closing load may fill
    // every middle row above the written one at once.
    always_ff @(posedge clk)
    begin
        if (lane.top_we)
        begin
            top_reg <= bcast.data;
        end
        for (int r = 0; r < MID_ROWS; r++)
        begin
            if ((lane.mid_we && (MID_ROW_W'(r) == bcast.mid_row)) ||
                (bcast.mid_fill && (MID_ROW_W'(r) > bcast.mid_row)))
            begin
                mid_reg[r] <= bcast.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane.bot_we)
        begin
            bot_mem[bcast.bot_row] <= bcast.data;
        end
        bot_rdata_reg <= bot_mem[bcast.node[BOT_ROW_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (lane.key_we)
        begin
            key_mem[bcast.key_row] <= bcast.data;
        end
        key_rdata_reg <= key_mem[bcast.node];
    end

    always_comb
    begin
        unique case (bcast.lvl)
            LVL_TOP: pivot = top_reg;
            LVL_MID: pivot = mid_reg[bcast.node[MID_ROW_W-1:0]];
            LVL_BOT: pivot = bot_rdata_reg;
            default: pivot = top_reg;
        endcase
    end

    // Slots past the key count read as the highest key.
    assign less      = $signed(pivot) < $signed(bcast.data);
    assign hit       = lane.leaf_live ? (key_rdata_reg == bcast.data) : bcast.high_hit;
    assign cnt_out   = cnt_in + CNT_W'(less);
    assign found_out = found_in | hit;

endmodule

`default_nettype wire

// ----- hw/rtl/sets_ctrl.sv -----
// ============================================================================
// sets_ctrl: sequencer of the eight-way tree search
// Takes transactions, holds the key count and key bounds, steps a query
// through the pivot levels and drives pivot updates for loads.
// ============================================================================
`default_nettype none

module sets_ctrl (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [sets_pkg::COUNT_W-1:0]          cfg_wdata,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  cmd,
    input  wire logic [sets_pkg::SLOT_W-1:0]           slot,
    input  wire logic signed [sets_pkg::KEY_W-1:0]     key,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       found,
    output sets_pkg::cell_bcast_t                      bcast,
    output sets_pkg::cell_lane_t [sets_pkg::LANES-1:0] lane_ctl,
    input  wire logic [sets_pkg::CNT_W-1:0]            chain_cnt,
    input  wire logic                                  chain_found
);
    import sets_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_FILL = 4'd2;
    localparam logic [3:0] S_L0   = 4'd3;
    localparam logic [3:0] S_L1   = 4'd4;
    localparam logic [3:0] S_R2   = 4'd5;
    localparam logic [3:0] S_L2   = 4'd6;
    localparam logic [3:0] S_RK   = 4'd7;
    localparam logic [3:0] S_LEAF = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    // Slot bit fields of the top, middle and bottom lanes.
    localparam int TOP_LSB = SLOT_W - LANE_W;
    localparam int MID_LSB = TOP_LSB - LANE_W;
    localparam int BOT_LSB = LANE_W;

    logic [3:0]              state_reg, state_next;
    logic [COUNT_W-1:0]      key_count_reg;
    logic signed [KEY_W-1:0] lowest_reg, lowest_next;
    logic signed [KEY_W-1:0] highest_reg, highest_next;
    logic [SLOT_W-1:0]       slot_reg;
    logic signed [KEY_W-1:0] data_reg;
    logic [NODE_W-1:0]       node_reg, node_next;
    logic [BOT_ROW_W-1:0]    fill_row_reg, fill_row_next;
    logic                    found_pend_reg, found_pend_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;

    logic [COUNT_W-1:0]      kc;
    logic                    in_accept;
    logic                    in_range;
    logic                    closes;
    logic                    reject;
    logic [LANE_W-1:0]       child;

    function automatic logic [LANE_W-1:0] sat_child(input logic [CNT_W-1:0] c);
        sat_child = c[CNT_W-1] ? '1 : c[LANE_W-1:0];
    endfunction

    assign kc        = (key_count_reg > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS)
                                                           : key_count_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_range  = {1'b0, slot_reg} < kc;
    assign closes    = ({1'b0, slot_reg} + COUNT_W'(1)) == kc;
    assign reject    = (kc == '0) || (data_reg < lowest_reg) || (highest_reg < data_reg);
    assign child     = sat_child(chain_cnt);

    always_comb
    begin
        logic [LANE_W-1:0] li;
        li              = '0;
        state_next      = state_reg;
        node_next       = node_reg;
        fill_row_next   = fill_row_reg;
        found_pend_next = found_pend_reg;
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;

        bcast.lvl      = LVL_TOP;
        bcast.data     = data_reg;
        bcast.node     = node_reg;
        bcast.key_row  = slot_reg[SLOT_W-1:BOT_LSB];
        bcast.mid_row  = slot_reg[SLOT_W-1:TOP_LSB];
        bcast.mid_fill = 1'b0;
        bcast.bot_row  = slot_reg[SLOT_W-1:MID_LSB];
        bcast.high_hit = (highest_reg == data_reg);
        lane_ctl       = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd == CMD_LOAD) ? S_LOAD : S_L0;
                end
            end
            S_LOAD:
            begin
                // A load inside the count refreshes the pivot of each subtree it
                // closes; the load of the last key also sets every later pivot.
                for (int i = 0; i < LANES; i++)
                begin
                    li = LANE_W'(i);
                    lane_ctl[i].key_we = (li == slot_reg[BOT_LSB-1:0]);
                    lane_ctl[i].top_we = in_range &&
                        (((&slot_reg[TOP_LSB-1:0] || closes) &&
                          (li == slot_reg[SLOT_W-1:TOP_LSB])) ||
                         (closes && (li > slot_reg[SLOT_W-1:TOP_LSB])));
                    lane_ctl[i].mid_we = in_range &&
                        (((&slot_reg[MID_LSB-1:0] || closes) &&
                          (li == slot_reg[TOP_LSB-1:MID_LSB])) ||
                         (closes && (li > slot_reg[TOP_LSB-1:MID_LSB])));
                    lane_ctl[i].bot_we = in_range &&
                        (((&slot_reg[BOT_LSB-1:0] || closes) &&
                          (li == slot_reg[MID_LSB-1:BOT_LSB])) ||
                         (closes && (li > slot_reg[MID_LSB-1:BOT_LSB])));
                end
                bcast.mid_fill = in_range && closes;
                if (in_range && (slot_reg == '0))
                begin
                    lowest_next = data_reg;
                end
                if (in_range && closes)
                begin
                    highest_next = data_reg;
                end
                if (in_range && closes && !(&slot_reg[SLOT_W-1:MID_LSB]))
                begin
                    fill_row_next = slot_reg[SLOT_W-1:MID_LSB] + BOT_ROW_W'(1);
                    state_next    = S_FILL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                bcast.bot_row = fill_row_reg;
                for (int i = 0; i < LANES; i++)
                begin
                    lane_ctl[i].bot_we = 1'b1;
                end
                if (&fill_row_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    fill_row_next = fill_row_reg + BOT_ROW_W'(1);
                end
            end
            S_L0:
            begin
                bcast.lvl = LVL_TOP;
                if (reject)
                begin
                    found_pend_next = 1'b0;
                    state_next      = S_FIN;
                end
                else
                begin
                    node_next  = NODE_W'(child);
                    state_next = S_L1;
                end
            end
            S_L1:
            begin
                bcast.lvl  = LVL_MID;
                node_next  = NODE_W'({node_reg[LANE_W-1:0], child});
                state_next = S_R2;
            end
            S_R2:
            begin
                state_next = S_L2;
            end
            S_L2:
            begin
                bcast.lvl  = LVL_BOT;
                node_next  = {node_reg[2*LANE_W-1:0], child};
                state_next = S_RK;
            end
            S_RK:
            begin
                state_next = S_LEAF;
            end
            S_LEAF:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    li = LANE_W'(i);
                    lane_ctl[i].leaf_live = {1'b0, node_reg, li} < kc;
                end
                found_pend_next = chain_found;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = found_pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
            lowest_reg    <= '0;
            highest_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lowest_reg    <= lowest_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                key_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            slot_reg <= slot;
            data_reg <= key;
        end
        node_reg       <= node_next;
        fill_row_reg   <= fill_row_next;
        found_pend_reg <= found_pend_next;
        found_reg      <= found_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/static_eight_way_tree_search.sv -----
// ============================================================================
// static_eight_way_tree_search: membership search over a sorted key table
// A sequencer and a row of eight lane cells that search a static tree of
// three eight-way pivot levels over eight-key leaves.
// ============================================================================
// A load transaction (cmd 0) writes one signed 64-bit key into its slot and
// refreshes the pivots of every subtree that the slot closes; the load of
// the last key of the count then rewrites every later bottom pivot row, one
// row a cycle, through the single write port of each lane's pivot memory,
// and holds the block until the last row is written. A query transaction
// (cmd 1) produces one result transaction with found, loaded into the
// result register after the walk down the levels, or straight after the
// top-level compare when the table is empty or the value lies outside the
// lowest..highest key range; the block takes its next transaction once the
// result is loaded. The query walks down the levels one level at a time,
// with a registered read of the bottom pivot memory and of the key memory
// in every lane. A finished result waits in its own register, so the next
// transaction is taken while the result is still stalled; a query whose
// result is ready while an earlier result is still stalled waits in its last
// step until that one is taken. Keys are expected in non-decreasing order;
// key_count is to be written through cfg_we and cfg_wdata only while the
// block is idle, which the block itself does not enforce; values above 4096
// act as 4096.
// ============================================================================
`default_nettype none

module static_eight_way_tree_search (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [sets_pkg::COUNT_W-1:0]      cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cmd,
    input  wire logic [sets_pkg::SLOT_W-1:0]       slot,
    input  wire logic signed [sets_pkg::KEY_W-1:0] key,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   found
);
    import sets_pkg::*;

    cell_bcast_t              bcast;
    cell_lane_t [LANES-1:0]   lane_ctl;

    // The cells form a chain: each adds its pivot compare to the running
    // child count and ORs its leaf match into the running found bit.
    logic [CNT_W-1:0]         cnt_chain   [LANES+1];
    logic                     found_chain [LANES+1];

    assign cnt_chain[0]   = '0;
    assign found_chain[0] = 1'b0;

    sets_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .slot        (slot),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .bcast       (bcast),
        .lane_ctl    (lane_ctl),
        .chain_cnt   (cnt_chain[LANES]),
        .chain_found (found_chain[LANES])
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_cell
        sets_cell u_cell (
            .clk       (clk),
            .bcast     (bcast),
            .lane      (lane_ctl[g]),
            .cnt_in    (cnt_chain[g]),
            .found_in  (found_chain[g]),
            .cnt_out   (cnt_chain[g+1]),
            .found_out (found_chain[g+1])
        );
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sets_checker.sv -----
// ============================================================================
// sets_checker: port-level checks of the tree search
// Watches the transaction ports of the top level over time.
// ============================================================================
`default_nettype none

module sets_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic found
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found)))
        else $error("stalled result transaction changed");

    // Every accepted transaction makes the block busy, so its input is stalled.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transaction");

    // A result only appears as the block finishes a busy phase.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

    // An idle block whose result is taken has nothing more to show.
    a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !in_stall) |=> !out_valid)
        else $error("result repeated or invented while idle");

endmodule

bind static_eight_way_tree_search sets_checker u_checker (.*);

`default_nettype wire
